FILE: sv/mwkp_pkg.sv
// ----------------------------------------------------------------------------
// mwkp_pkg
// Shared types and constants for the minimum prime window block.
// ----------------------------------------------------------------------------
package mwkp_pkg;

  localparam int unsigned FIELD_W     = 17;
  localparam int unsigned OUT_W       = 18;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;

  // all ones: no window length qualifies
  localparam logic [OUT_W-1:0] ANS_NONE = {OUT_W{1'b1}};

  // commands from controller to datapath
  typedef struct packed {
    logic fill;
    logic sv_init;
    logic sv_rd;
    logic sv_mark_init;
    logic sv_mark;
    logic sv_next;
    logic q_load;
    logic pre_init;
    logic pre_rd;
    logic pre_wr;
    logic bs_mid;
    logic chk_rd;
    logic chk_step;
    logic bs_pass;
    logic bs_fail;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_last;
    logic sv_done;
    logic map_bit;
    logic mark_done;
    logic q_empty;
    logic pre_last;
    logic bs_done;
    logic chk_ok;
    logic chk_last;
  } stat_t;

endpackage

FILE: sv/mwkp_ctrl.sv
// ----------------------------------------------------------------------------
// mwkp_ctrl
// Sequencer for sieve build, prefix build and binary search over lengths.
// ----------------------------------------------------------------------------
module mwkp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  mwkp_pkg::stat_t st,
  output mwkp_pkg::cmd_t  cmd
);
  import mwkp_pkg::*;

  typedef enum logic [12:0] {
    S_FILL    = 13'b0000000000001,
    S_SV_SQ   = 13'b0000000000010,
    S_SV_TEST = 13'b0000000000100,
    S_SV_BIT  = 13'b0000000001000,
    S_SV_MARK = 13'b0000000010000,
    S_IDLE    = 13'b0000000100000,
    S_Q_CHK   = 13'b0000001000000,
    S_PRE_RD  = 13'b0000010000000,
    S_PRE_WR  = 13'b0000100000000,
    S_BS_TEST = 13'b0001000000000,
    S_CHK_RD  = 13'b0010000000000,
    S_CHK_CMP = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.fill_last) begin
          cmd.sv_init = 1'b1;
          state_next  = S_SV_SQ;
        end
      end
      S_SV_SQ: state_next = S_SV_TEST;
      S_SV_TEST: begin
        if (st.sv_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.sv_rd  = 1'b1;
          state_next = S_SV_BIT;
        end
      end
      S_SV_BIT: begin
        if (st.map_bit) begin
          cmd.sv_mark_init = 1'b1;
          state_next       = S_SV_MARK;
        end else begin
          cmd.sv_next = 1'b1;
          state_next  = S_SV_SQ;
        end
      end
      S_SV_MARK: begin
        if (st.mark_done) begin
          cmd.sv_next = 1'b1;
          state_next  = S_SV_SQ;
        end else begin
          cmd.sv_mark = 1'b1;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.q_load = 1'b1;
          state_next = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (st.q_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pre_init = 1'b1;
          state_next   = S_PRE_RD;
        end
      end
      S_PRE_RD: begin
        cmd.pre_rd = 1'b1;
        state_next = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd.pre_wr = 1'b1;
        state_next = st.pre_last ? S_BS_TEST : S_PRE_RD;
      end
      S_BS_TEST: begin
        if (st.bs_done) begin
          state_next = S_DONE;
        end else begin
          cmd.bs_mid = 1'b1;
          state_next = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_next = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (!st.chk_ok) begin
          cmd.bs_fail = 1'b1;
          state_next  = S_BS_TEST;
        end else if (st.chk_last) begin
          cmd.bs_pass = 1'b1;
          state_next  = S_BS_TEST;
        end else begin
          cmd.chk_step = 1'b1;
          state_next   = S_CHK_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_FILL;
    endcase
  end

endmodule

FILE: sv/mwkp_dp.sv
// ----------------------------------------------------------------------------
// mwkp_dp
// Datapath: primality map, prefix count memory, counters and compares.
// ----------------------------------------------------------------------------
module mwkp_dp #(
  parameter int unsigned MAX_B = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mwkp_pkg::FIELD_W-1:0]        range_low,
  input  logic [mwkp_pkg::FIELD_W-1:0]        range_high,
  input  logic [mwkp_pkg::FIELD_W-1:0]        min_primes,
  input  mwkp_pkg::cmd_t                      cmd,
  output mwkp_pkg::stat_t                     st,
  output logic [mwkp_pkg::OUT_W-1:0]          window_length
);
  import mwkp_pkg::*;

  localparam int unsigned DEPTH = MAX_B + 2;
  localparam int unsigned LAST  = MAX_B + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned VW    = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

  logic          map_mem [DEPTH];
  logic [AW-1:0] pc_mem  [DEPTH];

  logic [CW-1:0]      j, i, span, k, lo, hi, mid, e;
  logic [2*CW-1:0]    sq;
  logic               map_q, empty;
  logic [AW-1:0]      low, acc, pa, pb;
  logic [FIELD_W-1:0] need;
  logic [OUT_W-1:0]   ans;

  logic [VW-1:0] rl_w, rh_w, rh_sat;
  logic [AW-1:0] map_ra, pre_addr, acc_next, diff;
  logic [CW-1:0] e_end;

  assign rl_w     = VW'(range_low);
  assign rh_w     = VW'(range_high);
  assign rh_sat   = (rh_w > VW'(MAX_B)) ? VW'(MAX_B) : rh_w;
  assign pre_addr = low + AW'(k - CW'(1));
  assign map_ra   = cmd.pre_rd ? pre_addr : i[AW-1:0];
  assign acc_next = acc + AW'(map_q);
  assign diff     = pb - pa;
  assign e_end    = e + mid;

  // sieve counters
  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
      i <= CW'(2);
    end else begin
      if (cmd.fill) begin
        j <= j + CW'(1);
      end else if (cmd.sv_mark_init) begin
        j <= sq[CW-1:0];
      end else if (cmd.sv_mark) begin
        j <= j + i;
      end
      if (cmd.sv_init) begin
        i <= CW'(2);
      end else if (cmd.sv_next) begin
        i <= i + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sq <= (2*CW)'(i) * (2*CW)'(i);
  end

  // primality map
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      map_mem[j[AW-1:0]] <= (j >= CW'(2));
    end else if (cmd.sv_mark) begin
      map_mem[j[AW-1:0]] <= 1'b0;
    end
    if (cmd.sv_rd || cmd.pre_rd) begin
      map_q <= map_mem[map_ra];
    end
  end

  // prefix counts
  always_ff @(posedge clk) begin
    if (cmd.pre_init) begin
      pc_mem[0] <= '0;
    end else if (cmd.pre_wr) begin
      pc_mem[k[AW-1:0]] <= acc_next;
    end
    if (cmd.chk_rd) begin
      pa <= pc_mem[e[AW-1:0]];
      pb <= pc_mem[e_end[AW-1:0]];
    end
  end

  // query registers
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      low   <= AW'(rl_w);
      span  <= CW'(rh_sat - rl_w + VW'(1));
      need  <= min_primes;
      empty <= (rl_w > rh_sat);
      ans   <= ANS_NONE;
    end
    if (cmd.pre_init) begin
      acc <= '0;
      k   <= CW'(1);
      lo  <= CW'(1);
      hi  <= span;
    end
    if (cmd.pre_wr) begin
      acc <= acc_next;
      k   <= k + CW'(1);
    end
    if (cmd.bs_mid) begin
      mid <= lo + ((hi - lo) >> 1);
      e   <= '0;
    end
    if (cmd.chk_step) begin
      e <= e + CW'(1);
    end
    if (cmd.bs_pass) begin
      ans <= OUT_W'(mid);
      hi  <= mid - CW'(1);
    end
    if (cmd.bs_fail) begin
      lo <= mid + CW'(1);
    end
    if (cmd.out_load) begin
      window_length <= ans;
    end
  end

  assign st.fill_last = (j == CW'(LAST));
  assign st.sv_done   = (sq > (2*CW)'(LAST));
  assign st.map_bit   = map_q;
  assign st.mark_done = (j > CW'(LAST));
  assign st.q_empty   = empty;
  assign st.pre_last  = (k == span);
  assign st.bs_done   = (lo > hi);
  assign st.chk_ok    = (VW'(diff) >= VW'(need));
  assign st.chk_last  = (e_end == span);

endmodule

FILE: sv/min_window_with_k_primes.sv
// ----------------------------------------------------------------------------
// min_window_with_k_primes
// Smallest window length whose every placement in [a,b] holds at least c primes.
// ----------------------------------------------------------------------------
// after reset the sieve is built: a fill pass over all MAX_B+2 entries, then S_SV_SQ,
//   S_SV_TEST, S_SV_BIT per index to sqrt(MAX_B+1), S_SV_MARK per prime and multiple;
//   no request till then; per request: S_Q_CHK, S_PRE_RD and S_PRE_WR per prefix entry,
//   then per search step S_BS_TEST and S_CHK_RD, S_CHK_CMP per window checked (at most
//   span-len+1), one prefix read pair each; S_DONE then loads the output register (after
//   S_Q_CHK for an empty range); one request in flight, the next taken once it is loaded
module min_window_with_k_primes #(
  parameter int unsigned MAX_B = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // range_low [16:0], range_high [33:17], min_primes [50:34]
  input  logic [mwkp_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // window_length [17:0]
  output logic [mwkp_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import mwkp_pkg::*;

  cmd_t             cmd;
  stat_t            st;
  logic [OUT_W-1:0] window_length;

  mwkp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mwkp_dp #(.MAX_B(MAX_B)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .range_low     (s_tdata[FIELD_W-1:0]),
    .range_high    (s_tdata[2*FIELD_W-1:FIELD_W]),
    .min_primes    (s_tdata[3*FIELD_W-1:2*FIELD_W]),
    .cmd           (cmd),
    .st            (st),
    .window_length (window_length)
  );

  assign m_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, window_length};

  // no request is taken while the sieve is being built
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request accepted during sieve build");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.q_load |-> (s_tvalid && s_tready))
    else $error("query latched without a request");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result shown without a finished search");

endmodule

FILE: tb/min_window_with_k_primes_test.sv
// ----------------------------------------------------------------------------
// min_window_with_k_primes_test
// Sends window queries through the request stream and checks each answer
// against a sieve-based prediction kept in the testbench, with random gaps on
// the request side and random stalls on the answer side.
// ----------------------------------------------------------------------------
module min_window_with_k_primes_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mwkp_pkg::*;

  localparam int unsigned MAX_B   = 65536;
  localparam int unsigned FMAX    = (1 << FIELD_W) - 1;
  localparam int unsigned N_DIR   = 20;
  localparam int unsigned N_RAND  = 80;

  typedef struct {
    int unsigned      low;
    int unsigned      high;
    int unsigned      count;
    bit               known;
    logic [OUT_W-1:0] answer;
  } query_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  bit               prime_map [0:MAX_B+1];
  logic [OUT_W-1:0] pending_answers [$];
  int unsigned      mismatches;
  int unsigned      stall_cycle;
  query_row_t       query_table [N_DIR];

  min_window_with_k_primes #(.MAX_B(MAX_B)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void build_sieve();
    for (int unsigned i = 0; i <= MAX_B + 1; i++) prime_map[i] = (i >= 2);
    for (int unsigned i = 2; i * i <= MAX_B + 1; i++) begin
      if (prime_map[i]) begin
        for (int unsigned j = i * i; j <= MAX_B + 1; j += i) prime_map[j] = 1'b0;
      end
    end
  endfunction

  // smallest length l such that every l-run inside [low, high] has at least count primes
  function automatic logic [OUT_W-1:0] min_window(int unsigned low, int unsigned high,
                                                  int unsigned count);
    int unsigned      span;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    bit               ok;
    int unsigned      prefix [];
    logic [OUT_W-1:0] best;
    best = ANS_NONE;
    if (high > MAX_B) high = MAX_B;
    if (low > high) return best;
    span = high - low + 1;
    prefix = new[span + 1];
    prefix[0] = 0;
    for (int unsigned k = 1; k <= span; k++)
      prefix[k] = prefix[k-1] + prime_map[low + k - 1];
    lo = 1;
    hi = span;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      ok = 1'b1;
      for (int unsigned st = 1; st + mid - 1 <= span && ok; st++)
        if (prefix[st + mid - 1] - prefix[st - 1] < count) ok = 1'b0;
      if (ok) begin
        best = OUT_W'(mid);
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best;
  endfunction

  // answer checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer %h with no request pending", m_tdata[OUT_W-1:0]);
      end else begin
        if (m_tdata[OUT_W-1:0] !== pending_answers[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("window_length mismatch: expected %h, got %h",
                     pending_answers[0], m_tdata[OUT_W-1:0]);
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // receiver stall pattern: phases of always ready, coin flip, and mostly stalled
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 97) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_query(int unsigned low, int unsigned high, int unsigned count,
                            logic [OUT_W-1:0] answer);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, FIELD_W'(count), FIELD_W'(high), FIELD_W'(low)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_answers = {pending_answers, answer};
    // burst ends at random; otherwise valid stays high for the next request
    if ($urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    query_row_t  row;
    int unsigned low;
    int unsigned high;
    int unsigned span;
    int unsigned count;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    stall_cycle = 0;
    mismatches  = 0;
    build_sieve();

    query_table = '{
      '{10, 5, 1, 1'b1, ANS_NONE},                   // empty interval
      '{1, 1, 0, 1'b1, OUT_W'(1)},                   // zero count, single point
      '{0, 30, 0, 1'b1, OUT_W'(1)},                  // zero count from zero bound
      '{0, 0, 1, 1'b1, ANS_NONE},                    // zero bound is not prime
      '{2, 2, 1, 1'b1, OUT_W'(1)},
      '{1, 1, 1, 1'b1, ANS_NONE},
      '{0, 100, 1, 1'b0, '0},
      '{1, 100, 25, 1'b0, '0},
      '{1, 100, 26, 1'b1, ANS_NONE},                 // count too large
      '{2, 50, FMAX, 1'b1, ANS_NONE},                // count at field max
      '{65536, 65536, 0, 1'b1, OUT_W'(1)},
      '{65536, 65536, 1, 1'b1, ANS_NONE},
      '{65400, FMAX, 2, 1'b0, '0},                   // bound above the sieve
      '{65537, FMAX, 0, 1'b1, ANS_NONE},             // empty after saturation
      '{FMAX, FMAX, 0, 1'b1, ANS_NONE},
      '{FMAX, 1, 0, 1'b1, ANS_NONE},
      '{65000, 65536, 3, 1'b0, '0},
      '{1, 4096, 3, 1'b0, '0},                       // one wide interval
      '{30000, 30500, 65536, 1'b1, ANS_NONE},
      '{1000, 1200, 5, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (query_table[i]) begin
      row = query_table[i];
      send_query(row.low, row.high, row.count,
                 row.known ? row.answer : min_window(row.low, row.high, row.count));
    end

    // hold off until every answer so far is back
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int n = 0; n < N_RAND; n++) begin
      low  = $urandom_range(0, MAX_B);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3000) : $urandom_range(1, 300);
      case ($urandom_range(0, 19))
        0: high = $urandom_range(0, FMAX);                       // often empty or saturated
        1: begin
          low  = $urandom_range(MAX_B - 300, FMAX);
          high = $urandom_range(MAX_B - 300, FMAX);
        end
        default: high = low + span - 1;
      endcase
      case ($urandom_range(0, 9))
        0: count = $urandom_range(0, FMAX);
        1: count = 0;
        default: count = $urandom_range(1, span / 8 + 3);
      endcase
      send_query(low, high, count, min_window(low, high, count));
    end

    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1s;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mwkp_pkg.sv
sv/mwkp_ctrl.sv
sv/mwkp_dp.sv
sv/min_window_with_k_primes.sv
tb/min_window_with_k_primes_test.sv
